// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; expects signals clk and rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define TCW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// text console cell writer. Depends on nothing.
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;
  localparam int COLOR_W  = 4;
  localparam int CFG_IDX_W = 1;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

  localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;
  localparam logic [CELL_W-1:0]  RESET_CELL = 16'h0F20;

  // RAM write source selected by the controller
  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_INIT  = 2'd1;
  localparam logic [1:0] WR_BLANK = 2'd2;
  localparam logic [1:0] WR_COPY  = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       exec_put;
    logic       home;
    logic       load_rdata;
    logic       cnt_inc;
    logic [1:0] wr_mode;
    logic       load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              idx_ok;
    logic              put_scroll;
    logic              cnt_last;
    logic              copy_end;
    logic              out_free;
  } tcw_sts_t;

endpackage

// ===== rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Sequencing state machine for the console: reset sweep, item execution,
// clear and scroll sweeps, result hand-off. Depends on tcw_pkg.
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_valid,
  output logic     s_ready,
  input  tcw_sts_t sts,
  output tcw_cmd_t cmd
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_RDATA = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_COPY  = 3'd5;
  localparam logic [2:0] S_FILL  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign s_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.wr_mode = WR_INIT;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (sts.func == FUNC_PUT) begin
          cmd.exec_put = 1'b1;
          state_next   = sts.put_scroll ? S_COPY : S_DONE;
        end else if (sts.func == FUNC_CLEAR) begin
          cmd.home   = 1'b1;
          state_next = S_CLEAR;
        end else if (sts.func == FUNC_READ) begin
          state_next = sts.idx_ok ? S_RDATA : S_DONE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RDATA: begin
        cmd.load_rdata = 1'b1;
        state_next     = S_DONE;
      end
      S_CLEAR: begin
        cmd.wr_mode = WR_BLANK;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) state_next = S_DONE;
      end
      S_COPY: begin
        cmd.wr_mode = WR_COPY;
        if (sts.copy_end) begin
          state_next = S_FILL;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_FILL: begin
        cmd.wr_mode = WR_BLANK;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

// ===== rtl/tcw_datapath.sv =====
// Console datapath: screen RAM, cursor, colour registers, sweep counter and
// output register. Depends on tcw_pkg and tcw_ram.
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tcw_cmd_t             cmd,
  output tcw_sts_t             sts,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [INDEX_W-1:0]   in_cell_index,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [CURSOR_W-1:0]  out_cursor_pos,
  output logic [CELL_W-1:0]    out_cell_data,
  output logic                 out_scrolled
);

  localparam int NCELLS = ROWS * COLS;
  localparam int COPY_N = (ROWS - 1) * COLS;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);

  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(NCELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_A   = ADDR_W'(COPY_N);
  localparam logic [COL_W:0]    COLS_E   = (COL_W + 1)'(COLS);
  localparam logic [ROW_W:0]    ROWS_E   = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);

  logic [FUNC_W-1:0]  func_q;
  logic [CHAR_W-1:0]  char_q;
  logic [INDEX_W-1:0] idx_q;
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic [ADDR_W-1:0]  cnt;
  logic [CELL_W-1:0]  data_q;
  logic               scrolled_q;

  logic [ADDR_W-1:0]  lin_pos;
  logic [CELL_W-1:0]  rdata;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ADDR_W:0]    copy_src;
  logic [CHAR_W-1:0]  attr;
  logic               ordinary;
  logic [COL_W:0]     col_a, col_b, col_tab;
  logic [ROW_W:0]     row_a, row_b;
  logic [ROW_W-1:0]   row_next;
  logic [COL_W-1:0]   col_next;
  logic               scroll;
  logic [CURSOR_W+ADDR_W-1:0] pos_ext;
  logic [INDEX_W+ADDR_W-1:0]  idx_ext;

  assign attr     = {bg_color, fg_color};
  assign lin_pos  = ADDR_W'(cur_row) * COLS_A + ADDR_W'(cur_col);
  assign ordinary = (char_q != CODE_NL) && (char_q != CODE_CR) &&
                    (char_q != CODE_TAB) && (char_q != CODE_BS);
  assign col_tab  = ({1'b0, cur_col} + (COL_W + 1)'(4)) & ~(COL_W + 1)'(3);

  // cursor motion for a put
  always_comb begin
    col_a = {1'b0, cur_col};
    row_a = {1'b0, cur_row};
    unique case (1'b1)
      (char_q == CODE_NL): begin
        col_a = '0;
        row_a = {1'b0, cur_row} + 1'b1;
      end
      (char_q == CODE_CR):  col_a = '0;
      (char_q == CODE_TAB): col_a = col_tab;
      (char_q == CODE_BS): begin
        if (cur_col != '0) begin
          col_a = {1'b0, cur_col} - 1'b1;
        end else if (cur_row != '0) begin
          row_a = {1'b0, cur_row} - 1'b1;
          col_a = {1'b0, COL_LAST};
        end
      end
      default: col_a = {1'b0, cur_col} + 1'b1;
    endcase
    col_b = col_a;
    row_b = row_a;
    if (col_a >= COLS_E) begin
      col_b = '0;
      row_b = row_a + 1'b1;
    end
    scroll   = (row_b >= ROWS_E);
    row_next = scroll ? ROW_LAST : row_b[ROW_W-1:0];
    col_next = col_b[COL_W-1:0];
  end

  assign copy_src = {1'b0, cnt} + {1'b0, COLS_A};
  assign idx_ext  = {{ADDR_W{1'b0}}, idx_q};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = {attr, BLANK_CHAR};
    ram_raddr = idx_ext[ADDR_W-1:0];
    if (cmd.exec_put && ordinary) begin
      ram_we    = 1'b1;
      ram_waddr = lin_pos;
      ram_wdata = {attr, char_q};
    end
    unique case (cmd.wr_mode)
      WR_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
      end
      WR_BLANK: ram_we = 1'b1;
      WR_COPY: begin
        ram_we    = (cnt != '0);
        ram_waddr = cnt - 1'b1;
        ram_wdata = rdata;
        ram_raddr = copy_src[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(NCELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row    <= '0;
      cur_col    <= '0;
      fg_color   <= FG_RESET;
      bg_color   <= BG_RESET;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_FG)) fg_color <= cfg_data;
      if (cfg_we && (cfg_index == CFG_BG)) bg_color <= cfg_data;
      if (cmd.capture) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.exec_put) begin
        cur_row <= row_next;
        cur_col <= col_next;
      end else if (cmd.home) begin
        cur_row <= '0;
        cur_col <= '0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pos_ext = {{CURSOR_W{1'b0}}, lin_pos};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q     <= in_func;
      char_q     <= in_char_code;
      idx_q      <= in_cell_index;
      data_q     <= '0;
      scrolled_q <= 1'b0;
    end else begin
      if (cmd.load_rdata) data_q <= rdata;
      if (cmd.exec_put && scroll) scrolled_q <= 1'b1;
    end
    if (cmd.load_out) begin
      out_cursor_pos <= pos_ext[CURSOR_W-1:0];
      out_cell_data  <= data_q;
      out_scrolled   <= scrolled_q;
    end
  end

  assign sts.func       = func_q;
  assign sts.idx_ok     = (int'(idx_q) < NCELLS);
  assign sts.put_scroll = scroll;
  assign sts.cnt_last   = (cnt == LAST_A);
  assign sts.copy_end   = (cnt == COPY_A);
  assign sts.out_free   = !out_valid || out_ready;

endmodule

// ===== rtl/text_console_cell_writer_top.sv =====
// Top level of the text console cell writer: stream ports, config port,
// controller and datapath. Depends on tcw_pkg, tcw_ctrl, tcw_datapath.
//
// Items are taken one at a time. A put that scrolls copies the screen up one
// row and blanks the bottom row, one cell per cycle through the single write
// port of the screen RAM. After reset the block fills the screen with 0x0F20
// before s_tready rises; colour writes are taken during that time. A finished
// result sits in the output register until taken, and the next item is
// accepted meanwhile.
module text_console_cell_writer_top
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [1:0] func, [9:2] char_code, [20:10] cell_index, [23:21] zero
  input  logic [S_DATA_W-1:0]  s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [10:0] cursor_pos, [26:11] cell_data, [27] scrolled, [31:28] zero
  output logic [M_DATA_W-1:0]  m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  logic [CURSOR_W-1:0] cursor_pos;
  logic [CELL_W-1:0]   cell_data;
  logic                scrolled;

  tcw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .s_valid(s_tvalid),
    .s_ready(s_tready),
    .sts    (sts),
    .cmd    (cmd)
  );

  tcw_datapath #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (s_tdata[1:0]),
    .in_char_code  (s_tdata[9:2]),
    .in_cell_index (s_tdata[20:10]),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .out_cursor_pos(cursor_pos),
    .out_cell_data (cell_data),
    .out_scrolled  (scrolled)
  );

  assign m_tdata = {4'b0, scrolled, cell_data, cursor_pos};

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level assertions for the console top level, bound to it below.
// Depends on tcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  localparam int NCELLS = ROWS * COLS;

  logic                m_stall;
  logic [CURSOR_W-1:0] m_cursor;
  logic [CELL_W-1:0]   m_cell;
  logic                m_scrolled;

  assign m_stall    = m_tvalid && !m_tready;
  assign m_cursor   = m_tdata[CURSOR_W-1:0];
  assign m_cell     = m_tdata[CURSOR_W +: CELL_W];
  assign m_scrolled = m_tdata[CURSOR_W + CELL_W];

  `TCW_ASSERT(a_out_hold, m_stall |=> m_tvalid && $stable(m_tdata), "result dropped on stall")
  `TCW_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "second transaction mid-item")
  `TCW_ASSERT_ALWAYS(a_init_sweep, $past(rst) |-> !s_tready, "ready during screen init")
  `TCW_ASSERT(a_cursor_range, !m_tvalid || (int'(m_cursor) < NCELLS), "cursor off screen")
  `TCW_ASSERT(a_scroll_no_data, m_tvalid && m_scrolled |-> m_cell == '0, "scroll with cell data")

endmodule

bind text_console_cell_writer_top tcw_checker #(
  .COLS(COLS),
  .ROWS(ROWS)
) u_tcw_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

// ===== test/text_console_cell_writer_top_test.sv =====
// Self-checking testbench for text_console_cell_writer_top: a cycle-free model
// of the screen, cursor and colours predicts every result transaction.
// Depends on tcw_pkg and the text_console_cell_writer_top RTL.
module text_console_cell_writer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLS = COLS_DEF;
  localparam int ROWS = ROWS_DEF;
  localparam int NCELLS = ROWS * COLS;
  localparam int ROW_W = 5;
  localparam int COL_W = 7;
  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 1600;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 32;
  localparam int WATCHDOG_LIMIT = 12000;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_pos;
    logic [CELL_W-1:0]   cell_data;
    logic                scrolled;
  } console_result_t;

  typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_LONG_STALLS} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_data;

  // predicted console state
  logic [CELL_W-1:0]  screen_model [NCELLS];
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic [COLOR_W-1:0] fg_q;
  logic [COLOR_W-1:0] bg_q;

  console_result_t pending_results[$];
  console_result_t oldest_result;
  int error_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_left = 0;
  int mode_left = 0;
  rx_mode_t rx_mode = RX_FREE;

  text_console_cell_writer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [CELL_W-1:0] coloured_cell(input logic [CHAR_W-1:0] ch);
    return {bg_q, fg_q, ch};
  endfunction

  function automatic void blank_cells(input int first, input int count);
    for (int i = first; i < first + count && i < NCELLS; i++)
      screen_model[i] = coloured_cell(BLANK_CHAR);
  endfunction

  function automatic logic apply_put(input logic [CHAR_W-1:0] ch);
    case (ch)
      CODE_NL: begin
        col_q = '0;
        row_q = row_q + 1'b1;
      end
      CODE_CR: col_q = '0;
      CODE_TAB: col_q = (col_q + 7'd4) & ~7'd3;
      CODE_BS: begin
        if (col_q > 0) begin
          col_q = col_q - 1'b1;
        end else if (row_q > 0) begin
          row_q = row_q - 1'b1;
          col_q = COL_W'(COLS - 1);
        end
      end
      default: begin
        screen_model[row_q * COLS + col_q] = coloured_cell(ch);
        col_q = col_q + 1'b1;
      end
    endcase
    if (col_q >= COLS) begin
      col_q = '0;
      row_q = row_q + 1'b1;
    end
    if (row_q >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLS; i++)
        screen_model[i] = screen_model[i + COLS];
      blank_cells((ROWS - 1) * COLS, COLS);
      row_q = ROW_W'(ROWS - 1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic console_result_t next_console_result(input logic [FUNC_W-1:0] fn,
                                                          input logic [CHAR_W-1:0] ch,
                                                          input logic [INDEX_W-1:0] idx);
    console_result_t r;
    r = '0;
    case (fn)
      FUNC_PUT: r.scrolled = apply_put(ch);
      FUNC_CLEAR: begin
        blank_cells(0, NCELLS);
        row_q = '0;
        col_q = '0;
      end
      FUNC_READ: if (idx < NCELLS) r.cell_data = screen_model[idx];
      default: ;
    endcase
    r.cursor_pos = CURSOR_W'(row_q * COLS + col_q);
    return r;
  endfunction

  function automatic logic [INDEX_W-1:0] cursor_index();
    return INDEX_W'(row_q * COLS + col_q);
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [CHAR_W-1:0] ch,
                           input logic [INDEX_W-1:0] idx);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'({idx, ch, fn});
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    pending_results.push_back(next_console_result(fn, ch, idx));
  endtask

  task automatic put(input logic [CHAR_W-1:0] ch);
    send_item(FUNC_PUT, ch, INDEX_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input logic [INDEX_W-1:0] idx);
    send_item(FUNC_READ, CHAR_W'($urandom_range(0, 255)), idx);
  endtask

  task automatic clear_screen();
    send_item(FUNC_CLEAR, CHAR_W'($urandom_range(0, 255)), INDEX_W'($urandom_range(0, 2047)));
  endtask

  // sender holds off until every outstanding result has been taken
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_colour(input logic [CFG_IDX_W-1:0] reg_idx,
                              input logic [COLOR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (reg_idx == CFG_FG) fg_q = value;
    else bg_q = value;
  endtask

  task automatic test_reset_state();
    read_cell(0);
    read_cell(INDEX_W'(NCELLS - 1));
    read_cell(INDEX_W'(NCELLS));
    read_cell('1);
    send_item(FUNC_NONE, '1, '1);
  endtask

  task automatic test_control_codes();
    put(CODE_BS);
    put(8'h00);
    put(8'hFF);
    put(8'h80);
    put(8'h7F);
    put(CODE_TAB);
    put(BLANK_CHAR);
    put(CODE_TAB);
    put(CODE_CR);
    put(CODE_NL);
    put(CODE_BS);
    put(8'h41);       // last column, wraps to next row
    put(CODE_BS);
    put(CODE_TAB);    // tab past the last column wraps
    read_cell(0);
    read_cell(3);
    read_cell(INDEX_W'(COLS - 1));
    read_cell(8);
  endtask

  task automatic test_scroll();
    clear_screen();
    put(8'h53);
    while (row_q != ROWS - 1) put(CODE_NL);
    put(8'h5A);
    read_cell(INDEX_W'((ROWS - 1) * COLS));
    put(CODE_NL);
    read_cell(INDEX_W'((ROWS - 2) * COLS));
    read_cell(INDEX_W'((ROWS - 1) * COLS));
    for (int i = 0; i < COLS; i++) put(CHAR_W'($urandom_range(8'h21, 8'h7E)));
    read_cell(INDEX_W'((ROWS - 2) * COLS + COLS - 1));
    put(CODE_BS);
    put(CODE_CR);
    read_cell(0);
  endtask

  task automatic test_colour_settings();
    logic [COLOR_W-1:0] fg_set [4] = '{4'h0, 4'hF, 4'h0, 4'hF};
    logic [COLOR_W-1:0] bg_set [4] = '{4'h0, 4'hF, 4'hF, 4'h0};
    for (int s = 0; s < 4; s++) begin
      drain_results();
      write_colour(CFG_FG, fg_set[s]);
      write_colour(CFG_BG, bg_set[s]);
      clear_screen();
      put(8'h43);
      put(8'hC3);
      read_cell(0);
      read_cell(1);
      read_cell(INDEX_W'(NCELLS - 1));
    end
  endtask

  task automatic send_random_item(input int nl_percent);
    int pick;
    int back;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      if ($urandom_range(0, 99) < nl_percent) put(CODE_NL);
      else if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: put(CODE_BS);
          1: put(CODE_TAB);
          default: put(CODE_CR);
        endcase
      end else put(CHAR_W'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      case ($urandom_range(0, 9))
        0: read_cell(INDEX_W'($urandom_range(0, 2047)));
        1, 2, 3, 4: read_cell(INDEX_W'($urandom_range(0, NCELLS - 1)));
        default: begin
          back = $urandom_range(0, 3);
          read_cell((cursor_index() >= back) ? cursor_index() - INDEX_W'(back) : '0);
        end
      endcase
    end else if (pick < 88) begin
      send_item(FUNC_NONE, CHAR_W'($urandom_range(0, 255)), INDEX_W'($urandom_range(0, 2047)));
    end else if (pick < 90) begin
      clear_screen();
    end else begin
      put(CHAR_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic();
    int sent;
    int session_len;
    int nl_percent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_results();
        write_colour(CFG_FG, COLOR_W'($urandom_range(0, 15)));
        write_colour(CFG_BG, COLOR_W'($urandom_range(0, 15)));
      end
      nl_percent = ($urandom_range(0, 1) == 0) ? 2 : 20;
      session_len = $urandom_range(20, 80);
      if ($urandom_range(0, 4) == 0) clear_screen();
      repeat (session_len) begin
        send_random_item(nl_percent);
        sent++;
      end
    end
  endtask

  // receiver stalls: free-running, choppy, or long stalls, mode changes over time
  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE: m_tready <= 1'b1;
        RX_CHOPPY: m_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12);
            m_tready <= 1'b0;
          end else begin
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with none expected: m_tdata=%h", m_tdata);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_tdata[10:0] !== oldest_result.cursor_pos) begin
          $error("cursor_pos: expected %0d, actual %0d", oldest_result.cursor_pos,
                 m_tdata[10:0]);
          error_count++;
        end
        if (m_tdata[26:11] !== oldest_result.cell_data) begin
          $error("cell_data: expected %h, actual %h", oldest_result.cell_data, m_tdata[26:11]);
          error_count++;
        end
        if (m_tdata[27] !== oldest_result.scrolled) begin
          $error("scrolled: expected %0b, actual %0b", oldest_result.scrolled, m_tdata[27]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("text_console_cell_writer_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int i = 0; i < NCELLS; i++) screen_model[i] = RESET_CELL;
    row_q = '0;
    col_q = '0;
    fg_q  = FG_RESET;
    bg_q  = BG_RESET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_control_codes();
    test_scroll();
    test_colour_settings();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("text_console_cell_writer_top regression: pass");
    end else begin
      $display("text_console_cell_writer_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_cell_writer_top.sv
rtl/tcw_checker.sv
test/text_console_cell_writer_top_test.sv
